[hw/rtl/vtd_pkg.sv]
package vtd_pkg;

  // fixed field widths
  localparam int unsigned PosWidth  = 17;
  localparam int unsigned ByteWidth = 8;

  // frame limit ceiling and framing constants
  localparam logic [PosWidth-1:0]  MaxFrameLimit = 17'd65560;
  localparam logic [ByteWidth-1:0] HdrMark       = 8'h23;
  localparam logic [ByteWidth-1:0] DelimMark     = 8'h7e;
  localparam logic [PosWidth-1:0]  HdrOverhead   = 17'd25;
  localparam logic [PosWidth-1:0]  HdrBytes      = 17'd24;
  localparam logic [PosWidth-1:0]  LenHiPos      = 17'd22;
  localparam logic [PosWidth-1:0]  LenLoPos      = 17'd23;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StBadStart = 2'd1,
    StTooLong  = 2'd2
  } status_e;

  typedef enum logic {
    OpData    = 1'b0,
    OpRestart = 1'b1
  } op_e;

  typedef enum logic {
    ModeLenHeader = 1'b0,
    ModeDelimiter = 1'b1
  } mode_e;

  typedef enum logic {
    CfgProtocolMode  = 1'b0,
    CfgMaxFrameBytes = 1'b1
  } cfg_index_e;

  typedef struct packed {
    op_e                  op;
    logic [ByteWidth-1:0] data_byte;
  } item_t;

  typedef struct packed {
    mode_e               protocol_mode;
    logic [PosWidth-1:0] max_frame_bytes;
  } cfg_t;

  typedef struct packed {
    logic [ByteWidth-1:0] byte_out;
    logic                 frame_last;
    logic [PosWidth-1:0]  frame_length;
    status_e              status;
  } result_t;

endpackage

[hw/rtl/vtd_stage.sv]
module vtd_stage #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [Width-1:0] data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [Width-1:0] data_o
);

  logic             valid_q, valid_d;
  logic [Width-1:0] data_q;
  logic             load;

  // stall upstream only while holding an item that cannot leave
  assign in_stall_o = valid_q & out_stall_i;
  assign load       = in_valid_i & ~in_stall_o;

  always_comb begin
    if (load) begin
      valid_d = 1'b1;
    end else if (out_stall_i) begin
      valid_d = valid_q;
    end else begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign data_o      = data_q;

endmodule

[hw/rtl/vtd_framer.sv]
module vtd_framer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  vtd_pkg::item_t   item_i,
  input  vtd_pkg::cfg_t    cfg_i,
  output vtd_pkg::result_t result_o
);

  import vtd_pkg::*;

  logic [PosWidth-1:0]  pos_q, pos_d;
  logic [ByteWidth-1:0] len_high_q, len_high_d;
  logic [PosWidth-1:0]  exp_size_q, exp_size_d;
  status_e              fail_q, fail_d;

  logic [PosWidth-1:0]  limit;
  logic [PosWidth:0]    pos_inc;
  logic [PosWidth-1:0]  exp_calc;
  logic [ByteWidth-1:0] b;
  logic                 last;
  logic [PosWidth-1:0]  flen;
  status_e              fail;

  // limit in force, next position and size from the header length
  assign limit    = (cfg_i.max_frame_bytes < MaxFrameLimit) ? cfg_i.max_frame_bytes
                                                            : MaxFrameLimit;
  assign pos_inc  = {1'b0, pos_q} + {{PosWidth{1'b0}}, 1'b1};
  assign exp_calc = {1'b0, len_high_q, item_i.data_byte} + HdrOverhead;
  assign b        = item_i.data_byte;

  // framing decision for the byte in the input register
  always_comb begin
    pos_d      = pos_q;
    len_high_d = len_high_q;
    exp_size_d = exp_size_q;
    fail_d     = fail_q;
    last       = 1'b0;
    flen       = '0;
    fail       = StOk;
    result_o   = '{byte_out: b, frame_last: 1'b0, frame_length: '0, status: StOk};
    priority if (item_i.op == OpRestart) begin
      pos_d      = '0;
      len_high_d = '0;
      exp_size_d = '0;
      fail_d     = StOk;
      result_o   = '{byte_out: '0, frame_last: 1'b0, frame_length: '0, status: StOk};
    end else if (fail_q != StOk) begin
      result_o.status = fail_q;
    end else begin
      if (cfg_i.protocol_mode == ModeLenHeader) begin
        priority if ((pos_q == '0 || pos_q == 17'd1) && b != HdrMark) begin
          fail = StBadStart;
        end else if (pos_q == LenHiPos) begin
          len_high_d = b;
        end else if (pos_q == LenLoPos) begin
          exp_size_d = exp_calc;
          if (exp_calc > limit) begin
            fail = StTooLong;
          end
        end else if (pos_q >= HdrBytes) begin
          if (pos_inc == {1'b0, exp_size_q}) begin
            last = 1'b1;
            flen = exp_size_q;
          end else if (pos_inc > {1'b0, exp_size_q}) begin
            fail = StTooLong;
          end
        end else begin
          // good start marks and header filler just advance
        end
      end else begin
        priority if (pos_q == '0 && b != DelimMark) begin
          fail = StBadStart;
        end else if (pos_q != '0 && b == DelimMark) begin
          last = 1'b1;
          flen = pos_inc[PosWidth-1:0];
        end else if (pos_inc >= {1'b0, limit}) begin
          fail = StTooLong;
        end else begin
          // byte inside the limit just advances
        end
      end
      // error wins over completion; otherwise advance or close the frame
      priority if (fail != StOk) begin
        fail_d = fail;
        last   = 1'b0;
        flen   = '0;
      end else if (last) begin
        pos_d = '0;
      end else begin
        pos_d = pos_inc[PosWidth-1:0];
      end
      result_o.frame_last   = last;
      result_o.frame_length = flen;
      result_o.status       = fail;
    end
  end

  // session state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      len_high_q <= '0;
      exp_size_q <= '0;
      fail_q     <= StOk;
    end else if (advance_i) begin
      pos_q      <= pos_d;
      len_high_q <= len_high_d;
      exp_size_q <= exp_size_d;
      fail_q     <= fail_d;
    end
  end

  // restart clears position and error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && item_i.op == OpRestart |=> pos_q == '0 && fail_q == StOk)
    else $error("restart did not clear session state");

  // a sticky error stays until restart
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && item_i.op == OpData && fail_q != StOk |=> fail_q == $past(fail_q))
    else $error("sticky error changed on a data byte");

  // completing a frame rewinds the position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && result_o.frame_last |=> pos_q == '0)
    else $error("position not rewound after frame end");

  // state moves only on a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_i |=> $stable(pos_q) && $stable(fail_q))
    else $error("session state changed without a transfer");

endmodule

[hw/rtl/vehicle_telematics_deframer.sv]
// Byte-stream frame delimiter for length-header (0x23 0x23 start, big-endian
// body length in bytes 22 and 23, frame = body + 25) or 0x7e-delimited
// framing, chosen by protocol_mode. Every accepted item yields exactly one
// result: the byte with a last-of-frame flag, the frame length on the last
// byte and a status; a bad start or over-long frame is sticky until a restart
// item. One item per clock is sustained while the receiver does not stall; an
// input register is followed by a result register, with the position counter
// compare between them. Configuration writes are always ready and are meant
// to be made while no item is in flight.
module vehicle_telematics_deframer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input items
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                op_i,
  input  logic [7:0]                          data_byte_i,
  // result items
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [7:0]                          byte_out_o,
  output logic                                frame_last_o,
  output logic [16:0]                         frame_length_o,
  output logic [1:0]                          status_o,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic                                cfg_index_i,
  input  logic [16:0]                         cfg_data_i
);

  import vtd_pkg::*;

  item_t   in_item, stage_item;
  result_t result, out_result;
  cfg_t    cfg_q;
  logic    stage_valid, stage_stall;
  logic    advance;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.protocol_mode   <= ModeLenHeader;
      cfg_q.max_frame_bytes <= MaxFrameLimit;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_e'(cfg_index_i))
        CfgProtocolMode:  cfg_q.protocol_mode   <= mode_e'(cfg_data_i[0]);
        CfgMaxFrameBytes: cfg_q.max_frame_bytes <= cfg_data_i;
        default:          cfg_q                 <= cfg_q;
      endcase
    end
  end

  // input register
  assign in_item = '{op: op_e'(op_i), data_byte: data_byte_i};

  vtd_stage #(
    .Width($bits(item_t))
  ) u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_i      (in_item),
    .out_valid_o (stage_valid),
    .out_stall_i (stage_stall),
    .data_o      (stage_item)
  );

  // framing logic, state advances when the item moves into the result register
  logic out_in_stall;
  assign stage_stall = out_in_stall;
  assign advance     = stage_valid & ~out_in_stall;

  vtd_framer u_framer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (stage_item),
    .cfg_i     (cfg_q),
    .result_o  (result)
  );

  // result register
  vtd_stage #(
    .Width($bits(result_t))
  ) u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (stage_valid),
    .in_stall_o  (out_in_stall),
    .data_i      (result),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_o      (out_result)
  );

  assign byte_out_o     = out_result.byte_out;
  assign frame_last_o   = out_result.frame_last;
  assign frame_length_o = out_result.frame_length;
  assign status_o       = out_result.status;

endmodule

[verif/vehicle_telematics_deframer_tb.sv]
module vehicle_telematics_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vtd_pkg::*;

  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned SettleCycles = 6;
  localparam longint unsigned TimeoutNs = 2_000_000;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  // input channel
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  op_e                  in_op    = OpData;
  logic [ByteWidth-1:0] in_byte  = '0;

  // result channel
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ByteWidth-1:0] res_byte;
  logic                 res_last;
  logic [PosWidth-1:0]  res_length;
  logic [1:0]           res_status;

  // configuration channel
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  cfg_index_e           cfg_index = CfgProtocolMode;
  logic [PosWidth-1:0]  cfg_data  = '0;

  vehicle_telematics_deframer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .op_i           (in_op),
    .data_byte_i    (in_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .byte_out_o     (res_byte),
    .frame_last_o   (res_last),
    .frame_length_o (res_length),
    .status_o       (res_status),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  // clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // stimulus and expectation stores
  item_t   pending_items[$];
  result_t expected_results[$];
  logic [ByteWidth-1:0] frame_buf[$];

  // idling knobs, percent per cycle
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  logic        hold_off      = 1'b0;
  event        hold_ev;

  // configuration as seen by the frame generator
  mode_e               gen_mode  = ModeLenHeader;
  logic [PosWidth-1:0] gen_limit = MaxFrameLimit;
  logic                need_restart = 1'b0;
  int unsigned         gen_count = 0;

  // tracked block configuration and framing state
  mode_e               cur_mode  = ModeLenHeader;
  logic [PosWidth-1:0] cur_limit = MaxFrameLimit;
  logic [PosWidth-1:0] trk_pos   = '0;
  logic [7:0]          trk_len_hi = '0;
  logic [PosWidth-1:0] trk_size  = '0;
  status_e             trk_failure = StOk;

  // run statistics
  int unsigned n_errors    = 0;
  int unsigned n_items     = 0;
  int unsigned n_results   = 0;
  int unsigned n_frames    = 0;
  int unsigned n_bad_start = 0;
  int unsigned n_too_long  = 0;

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch on %s: got %0d, expected %0d (result %0d, %0t)",
             what, got, want, n_results, $realtime);
    n_errors++;
  endtask

  // framing step: one byte or restart in, one result out, state advanced
  function automatic result_t deframe_step(item_t it);
    result_t     r;
    int unsigned pos;
    int unsigned lim;
    int unsigned size;
    logic        last;
    int unsigned flen;
    status_e     fail;
    pos  = trk_pos;
    lim  = (cur_limit < MaxFrameLimit) ? cur_limit : MaxFrameLimit;
    last = 1'b0;
    flen = 0;
    fail = StOk;
    r    = '0;
    if (it.op == OpRestart) begin
      trk_pos     = '0;
      trk_len_hi  = '0;
      trk_size    = '0;
      trk_failure = StOk;
      return r;
    end
    r.byte_out = it.data_byte;
    // sticky failure: pass the byte, repeat the error
    if (trk_failure != StOk) begin
      r.status = trk_failure;
      return r;
    end
    if (cur_mode == ModeLenHeader) begin
      if ((pos == 0 || pos == 1) && it.data_byte != HdrMark) begin
        fail = StBadStart;
      end else if (pos == LenHiPos) begin
        trk_len_hi = it.data_byte;
      end else if (pos == LenLoPos) begin
        size     = {trk_len_hi, it.data_byte} + HdrOverhead;
        trk_size = size[PosWidth-1:0];
        if (size > lim) fail = StTooLong;
      end else if (pos >= HdrBytes) begin
        if (pos + 1 == trk_size) begin
          last = 1'b1;
          flen = trk_size;
        end else if (pos + 1 > trk_size) begin
          fail = StTooLong;
        end
      end
    end else begin
      if (pos == 0 && it.data_byte != DelimMark) begin
        fail = StBadStart;
      end else if (pos != 0 && it.data_byte == DelimMark) begin
        last = 1'b1;
        flen = pos + 1;
      end else if (pos + 1 >= lim) begin
        fail = StTooLong;
      end
    end
    if (fail != StOk) begin
      trk_failure = fail;
      last = 1'b0;
      flen = 0;
    end else if (last) begin
      trk_pos = '0;
    end else begin
      trk_pos = PosWidth'(pos + 1);
    end
    r.frame_last   = last;
    r.frame_length = PosWidth'(flen);
    r.status       = fail;
    return r;
  endfunction

  // driver: next pending item once the current one is taken
  always @(posedge clk_i or negedge rst_n) begin : driver
    item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_items.pop_front();
        in_valid <= 1'b1;
        in_op    <= nxt.op;
        in_byte  <= nxt.data_byte;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall
  always @(posedge clk_i) begin
    out_stall <= hold_off || ($urandom_range(99) < stall_pct);
  end

  // long receiver hold-off, counted here
  always begin
    @(hold_ev);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // monitor: config and input transfers feed the predictor, results are checked
  always @(posedge clk_i) begin : monitor
    item_t   it;
    result_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CfgProtocolMode) cur_mode = mode_e'(cfg_data[0]);
        else cur_limit = cfg_data;
      end
      if (in_valid && !in_stall) begin
        it.op        = in_op;
        it.data_byte = in_byte;
        expected_results.push_back(deframe_step(it));
        n_items++;
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, byte", res_byte, 0);
        end else begin
          want = expected_results.pop_front();
          if (res_byte != want.byte_out)
            report_mismatch("byte_out", res_byte, want.byte_out);
          if (res_last != want.frame_last)
            report_mismatch("frame_last", res_last, want.frame_last);
          if (res_length != want.frame_length)
            report_mismatch("frame_length", res_length, want.frame_length);
          if (res_status != want.status)
            report_mismatch("status", res_status, want.status);
          if (want.frame_last) n_frames++;
          if (want.status == StBadStart) n_bad_start++;
          if (want.status == StTooLong) n_too_long++;
        end
        n_results++;
      end
    end
  end

  task automatic push_item(op_e op, logic [ByteWidth-1:0] b);
    item_t it;
    it.op        = op;
    it.data_byte = b;
    pending_items.push_back(it);
    gen_count++;
  endtask

  task automatic push_frame();
    foreach (frame_buf[i]) push_item(OpData, frame_buf[i]);
  endtask

  // 24 header bytes: two marks, filler, big-endian body length
  task automatic build_hdr_header(logic [15:0] body);
    frame_buf.delete();
    frame_buf.push_back(HdrMark);
    frame_buf.push_back(HdrMark);
    repeat (20) frame_buf.push_back(8'($urandom));
    frame_buf.push_back(body[15:8]);
    frame_buf.push_back(body[7:0]);
  endtask

  task automatic build_hdr_frame(logic [15:0] body);
    build_hdr_header(body);
    repeat (int'(body) + 1) frame_buf.push_back(8'($urandom));
  endtask

  task automatic build_delim_frame(int unsigned n);
    logic [7:0] b;
    frame_buf.delete();
    frame_buf.push_back(DelimMark);
    repeat (n) begin
      b = 8'($urandom);
      frame_buf.push_back((b == DelimMark) ? 8'h7d : b);
    end
    frame_buf.push_back(DelimMark);
  endtask

  // well-formed frame for the current mode; flags one that will overrun the limit
  task automatic build_frame();
    int unsigned lim;
    int unsigned sz;
    lim = (gen_limit < MaxFrameLimit) ? gen_limit : MaxFrameLimit;
    sz  = ($urandom_range(15) == 0) ? $urandom_range(400) : $urandom_range(12);
    if (gen_mode == ModeLenHeader) begin
      build_hdr_frame(16'(sz));
      if (sz + 25 > lim) need_restart = 1'b1;
    end else begin
      build_delim_frame(sz);
      if (sz + 1 >= lim) need_restart = 1'b1;
    end
  endtask

  // mostly well-formed frames with random content, some broken ones and noise
  task automatic gen_random(int unsigned n);
    int unsigned start;
    int unsigned sel;
    int unsigned keep;
    start = gen_count;
    while (gen_count - start < n) begin
      sel = $urandom_range(99);
      if (need_restart || $urandom_range(3) == 0) begin
        push_item(OpRestart, 8'($urandom));
        need_restart = 1'b0;
      end
      if (sel < 80) begin
        build_frame();
        push_frame();
      end else if (sel < 90) begin
        build_frame();
        if ($urandom_range(1) == 1) begin
          frame_buf[(gen_mode == ModeLenHeader) ? $urandom_range(1) : 0] = 8'($urandom);
        end else begin
          keep = $urandom_range(frame_buf.size() - 1);
          while (frame_buf.size() > keep) void'(frame_buf.pop_back());
        end
        push_frame();
        need_restart = 1'b1;
      end else begin
        repeat ($urandom_range(1, 4)) push_item(op_e'($urandom_range(1)), 8'($urandom));
        need_restart = 1'b1;
      end
    end
  endtask

  task automatic write_cfg(cfg_index_e idx, logic [PosWidth-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CfgProtocolMode) gen_mode = mode_e'(val[0]);
    else gen_limit = val;
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_idle(int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
  endtask

  // run limit
  initial begin
    #(TimeoutNs);
    $display("timeout with %0d items pending and %0d results outstanding",
             pending_items.size(), expected_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // length-header framing at the widest limit, no idling
    set_idle(0, 0);
    write_cfg(CfgProtocolMode, ModeLenHeader);
    write_cfg(CfgMaxFrameBytes, MaxFrameLimit);
    push_item(OpRestart, 8'hff);
    build_hdr_frame(16'd0);
    push_frame();
    build_hdr_frame(16'd2);
    push_frame();
    // bad first mark, then sticky bytes
    push_item(OpData, 8'h00);
    push_item(OpData, 8'hff);
    push_item(OpData, HdrMark);
    push_item(OpRestart, 8'h00);
    // bad second mark
    push_item(OpData, HdrMark);
    push_item(OpData, 8'hff);
    push_item(OpRestart, 8'h5a);
    gen_random(150);
    drain();

    // tight limit in length-header mode, sender mostly idle
    set_idle(86, 0);
    write_cfg(CfgMaxFrameBytes, 17'd30);
    push_item(OpRestart, 8'h00);
    build_hdr_frame(16'd5);
    push_frame();
    build_hdr_frame(16'd6);
    push_frame();
    push_item(OpRestart, 8'h00);
    gen_random(150);
    drain();

    // delimiter framing, widest limit, receiver mostly stalled
    set_idle(0, 86);
    write_cfg(CfgProtocolMode, ModeDelimiter);
    write_cfg(CfgMaxFrameBytes, MaxFrameLimit);
    push_item(OpRestart, 8'h00);
    push_item(OpData, DelimMark);
    push_item(OpData, DelimMark);
    push_item(OpData, DelimMark);
    push_item(OpData, 8'h00);
    push_item(OpData, 8'hff);
    push_item(OpData, DelimMark);
    push_item(OpData, HdrMark);
    push_item(OpData, DelimMark);
    push_item(OpRestart, 8'h00);
    gen_random(150);
    drain();

    // delimiter framing with a limit of five, both sides idling
    set_idle(31, 31);
    write_cfg(CfgMaxFrameBytes, 17'd5);
    push_item(OpRestart, 8'h00);
    build_delim_frame(3);
    push_frame();
    push_item(OpData, DelimMark);
    repeat (4) push_item(OpData, 8'h01);
    push_item(OpData, DelimMark);
    push_item(OpRestart, 8'h00);
    gen_random(120);
    drain();

    // limit of one: a delimiter byte overruns, another first byte is a bad start, header frames fail at the length
    set_idle(0, 0);
    write_cfg(CfgMaxFrameBytes, 17'd1);
    push_item(OpRestart, 8'h00);
    push_item(OpData, DelimMark);
    push_item(OpRestart, 8'h00);
    push_item(OpData, 8'h42);
    push_item(OpRestart, 8'h00);
    drain();
    write_cfg(CfgProtocolMode, ModeLenHeader);
    build_hdr_frame(16'd0);
    push_frame();
    push_item(OpRestart, 8'h00);
    drain();

    // mode switch while a frame is open
    write_cfg(CfgMaxFrameBytes, MaxFrameLimit);
    write_cfg(CfgProtocolMode, ModeDelimiter);
    build_delim_frame(29);
    void'(frame_buf.pop_back());
    push_frame();
    drain();
    write_cfg(CfgProtocolMode, ModeLenHeader);
    repeat (3) push_item(OpData, 8'($urandom));
    push_item(OpRestart, 8'h00);
    drain();
    write_cfg(CfgProtocolMode, ModeDelimiter);
    push_item(OpData, DelimMark);
    push_item(OpData, 8'h11);
    push_item(OpData, 8'h22);
    drain();
    write_cfg(CfgProtocolMode, ModeLenHeader);
    repeat (19) push_item(OpData, 8'($urandom));
    push_item(OpData, 8'h00);
    push_item(OpData, 8'h00);
    push_item(OpData, 8'hc3);
    push_item(OpRestart, 8'h00);
    drain();

    // long receiver hold-off while the sender keeps offering
    gen_random(150);
    -> hold_ev;
    drain();

    // header claiming the largest body, one over a limit just below it
    write_cfg(CfgMaxFrameBytes, MaxFrameLimit - 17'd1);
    push_item(OpRestart, 8'h00);
    build_hdr_header(16'hffff);
    push_frame();
    push_item(OpData, 8'h00);
    push_item(OpRestart, 8'h00);
    drain();

    // delimiter framing again, both sides idling
    set_idle(31, 31);
    write_cfg(CfgProtocolMode, ModeDelimiter);
    write_cfg(CfgMaxFrameBytes, MaxFrameLimit);
    gen_random(200);
    drain();

    $display("covered %0d input transfers and %0d results: %0d frames closed,",
             n_items, n_results, n_frames);
    $display("%0d bad-start and %0d too-long reports, both framing modes, limits 1 to %0d",
             n_bad_start, n_too_long, MaxFrameLimit);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
